@@ hw/rtl/ffha_pkg.sv @@
// shared types and codes for the first-fit heap allocator
`default_nettype none
package ffha_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_CALLOC = 2'd2,
    OP_RESIZE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } st_e;

  localparam logic [7:0] CFG_HEAP_BASE  = 8'd0;
  localparam logic [7:0] CFG_HEAP_LIMIT = 8'd1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;

  typedef enum logic [2:0] {
    RA_NONE, RA_SCAN, RA_KM1, RA_J, RA_J1, RA_K1
  } ra_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_K, WR_SPLIT, WR_ALLOC, WR_FREE, WR_MERGE, WR_GROW
  } wr_e;

  typedef enum logic [1:0] {
    CX_ALLOC, CX_FREE, CX_RESZ, CX_RESZ2
  } ctx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MUL, S_MULCHK, S_A0, S_SCAN_RD, S_SCAN_CHK, S_FOUND,
    S_G1, S_G2, S_G3, S_SPL, S_SH_RD, S_SH_WR, S_SPLIT_WR, S_AFIN,
    S_REL, S_MG0, S_MG1, S_MG2, S_RM_RD, S_RM_WR, S_MG_END, S_FIN
  } state_e;

  typedef struct packed {
    logic latch;
    logic set_req_size;
    logic set_req_prod;
    logic mul;
    logic need_calc;
    logic scan_clr;
    logic scan_inc;
    logic scan_find;
    logic take;
    logic load_ent;
    logic grow_prep;
    logic k_load_cnt;
    logic k_dec;
    logic k_inc;
    logic k_load_j1;
    logic cnt_dec;
    logic j_load_idx;
    logic j_load_idx_m1;
    logic res_ent;
    logic res_ptr;
    logic copy_old;
    logic old_load;
    logic st_set;
    st_e  st_val;
    logic out_load;
    ra_e  raddr;
    wr_e  wr;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic ptr_zero;
    logic size_zero;
    logic req_zero;
    logic prod_hi_nz;
    logic scan_end;
    logic scan_match;
    logic grow_fail;
    logic split_ok;
    logic sh_more;
    logic mg_skip;
    logic mg_ok;
    logic rm_more;
    logic idx_zero;
    logic fits;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/ffha_datapath.sv @@
// block table memory, counters, arithmetic and result registers
`default_nettype none
module ffha_datapath
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS       = 64,
  parameter int HEADER_BYTES     = 20,
  parameter int MIN_SPLIT_BYTES  = 32,
  parameter int GROW_CHUNK_BYTES = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic [31:0] item_count_i,
  input  wire logic [31:0] block_address_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [31:0]      result_address_o,
  output logic [1:0]       status_o,
  output logic [31:0]      copy_bytes_o
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAXC   = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONEC   = CW'(1);
  localparam logic [33:0]   HDR34  = 34'(HEADER_BYTES);
  localparam logic [33:0]   MIN34  = 34'(MIN_SPLIT_BYTES);
  localparam logic [33:0]   CHK34  = 34'(GROW_CHUNK_BYTES);
  localparam logic [34:0]   SPAN35 = 35'h1_0000_0000;

  entry_t mem_q [MAX_BLOCKS];
  entry_t rd_q, ent_q, wdata;
  logic   wr_en;
  logic [IW-1:0] waddr, raddr;
  logic [CW-1:0] raddr_full, waddr_full;

  logic [1:0]  cmd_q;
  logic [31:0] size_q, count_q, ptr_q, req_q, old_q;
  logic [63:0] prod_q;
  logic [32:0] need_q, top_q;
  logic [33:0] want_q;
  logic [31:0] base_q, limit_q, used_q;
  logic [CW-1:0] cnt_q, i_q, k_q, j_q, idx_q;
  logic [31:0] res_q, copy_q;
  st_e         st_q;
  logic        out_valid_q;
  logic [31:0] out_addr_q, out_copy_q;
  logic [1:0]  out_st_q;

  logic [33:0] split_need, merge_end;
  logic [34:0] used_sum, top_sum;
  logic [32:0] grow_start;

  assign split_need = {1'b0, need_q} + HDR34 + MIN34;
  assign merge_end  = {2'b00, ent_q.start} + {2'b00, ent_q.size} + HDR34;
  assign used_sum   = {3'b000, used_q} + {1'b0, want_q};
  assign top_sum    = {2'b00, top_q} + {1'b0, want_q};
  assign grow_start = top_q + HDR34[32:0];

  // read address select
  always_comb begin
    case (cmd_i.raddr)
      RA_SCAN: raddr_full = i_q;
      RA_KM1:  raddr_full = k_q - ONEC;
      RA_J:    raddr_full = j_q;
      RA_J1:   raddr_full = j_q + ONEC;
      RA_K1:   raddr_full = k_q + ONEC;
      default: raddr_full = '0;
    endcase
    raddr = raddr_full[IW-1:0];
  end

  // write port select
  always_comb begin
    wr_en      = 1'b1;
    waddr_full = idx_q;
    wdata      = ent_q;
    unique case (cmd_i.wr)
      WR_K: begin
        waddr_full = k_q;
        wdata      = rd_q;
      end
      WR_SPLIT: begin
        waddr_full  = idx_q + ONEC;
        wdata.start = 32'({2'b00, ent_q.start} + {1'b0, need_q} + HDR34);
        wdata.size  = 32'({2'b00, ent_q.size} - {1'b0, need_q} - HDR34);
        wdata.free  = 1'b1;
      end
      WR_ALLOC: wdata.free = 1'b0;
      WR_FREE:  wdata.free = 1'b1;
      WR_MERGE: begin
        waddr_full = j_q;
        wdata.size = 32'({2'b00, ent_q.size} + {2'b00, rd_q.size} + HDR34);
        wdata.free = 1'b1;
      end
      WR_GROW: begin
        waddr_full  = cnt_q;
        wdata.start = grow_start[31:0];
        wdata.size  = 32'(want_q - HDR34);
        wdata.free  = 1'b1;
      end
      default: wr_en = 1'b0;
    endcase
    waddr = waddr_full[IW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= command_i;
      size_q  <= request_size_i;
      count_q <= item_count_i;
      ptr_q   <= block_address_i;
      res_q   <= '0;
      copy_q  <= '0;
    end
    if (cmd_i.mul)          prod_q <= 64'(count_q) * 64'(size_q);
    if (cmd_i.set_req_size) req_q <= size_q;
    if (cmd_i.set_req_prod) req_q <= prod_q[31:0];
    if (cmd_i.need_calc)    need_q <= ({1'b0, req_q} + 33'd7) & ~33'd7;
    if (cmd_i.grow_prep) begin
      want_q <= ({1'b0, need_q} + HDR34 < CHK34) ? CHK34 : {1'b0, need_q} + HDR34;
      top_q  <= {1'b0, base_q} + {1'b0, used_q};
    end
    if (cmd_i.take || cmd_i.load_ent) ent_q <= rd_q;
    if (cmd_i.take)                   idx_q <= i_q;
    if (cmd_i.wr == WR_GROW) begin
      ent_q <= wdata;
      idx_q <= cnt_q;
    end
    if (cmd_i.wr == WR_SPLIT) ent_q.size <= need_q[31:0];
    if (cmd_i.k_load_cnt) k_q <= cnt_q;
    if (cmd_i.k_dec)      k_q <= k_q - ONEC;
    if (cmd_i.k_inc)      k_q <= k_q + ONEC;
    if (cmd_i.k_load_j1)  k_q <= j_q + ONEC;
    if (cmd_i.j_load_idx)    j_q <= idx_q;
    if (cmd_i.j_load_idx_m1) j_q <= idx_q - ONEC;
    if (cmd_i.res_ent)  res_q  <= ent_q.start;
    if (cmd_i.res_ptr)  res_q  <= ptr_q;
    if (cmd_i.old_load) old_q  <= ent_q.size;
    if (cmd_i.copy_old) copy_q <= old_q;
    if (cmd_i.out_load) begin
      out_addr_q <= res_q;
      out_copy_q <= copy_q;
      out_st_q   <= st_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 32'd4096;
      limit_q     <= 32'd1048576;
      cnt_q       <= '0;
      used_q      <= '0;
      i_q         <= '0;
      st_q        <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CFG_HEAP_BASE)  base_q  <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CFG_HEAP_LIMIT) limit_q <= cfg_data_i;
      if (cmd_i.wr == WR_GROW) begin
        cnt_q  <= cnt_q + ONEC;
        used_q <= used_sum[31:0];
      end
      if (cmd_i.wr == WR_SPLIT) cnt_q <= cnt_q + ONEC;
      if (cmd_i.cnt_dec)        cnt_q <= cnt_q - ONEC;
      if (cmd_i.scan_clr)       i_q <= '0;
      if (cmd_i.scan_inc)       i_q <= i_q + ONEC;
      if (cmd_i.latch)          st_q <= ST_DONE;
      if (cmd_i.st_set)         st_q <= cmd_i.st_val;
      if (cmd_i.out_load)       out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.ptr_zero   = (ptr_q == '0);
    stat_o.size_zero  = (size_q == '0);
    stat_o.req_zero   = (req_q == '0);
    stat_o.prod_hi_nz = (prod_q[63:32] != '0);
    stat_o.scan_end   = (i_q >= cnt_q);
    stat_o.scan_match = cmd_i.scan_find ? (rd_q.start == ptr_q && !rd_q.free)
                                        : (rd_q.free && {1'b0, rd_q.size} >= need_q);
    stat_o.grow_fail  = (cnt_q >= MAXC) || (used_sum > {3'b000, limit_q}) ||
                        (top_sum > SPAN35) || ({1'b0, top_q} + HDR34 == '0);
    stat_o.split_ok   = ({2'b00, ent_q.size} >= split_need) && (cnt_q < MAXC);
    stat_o.sh_more    = ({1'b0, k_q} > {1'b0, idx_q} + {1'b0, ONEC});
    stat_o.mg_skip    = ({1'b0, j_q} + {1'b0, ONEC} >= {1'b0, cnt_q});
    stat_o.mg_ok      = ent_q.free && rd_q.free && (merge_end == {2'b00, rd_q.start});
    stat_o.rm_more    = ({1'b0, k_q} + {1'b0, ONEC} < {1'b0, cnt_q});
    stat_o.idx_zero   = (idx_q == '0);
    stat_o.fits       = (ent_q.size >= size_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign status_o         = out_st_q;
  assign copy_bytes_o     = out_copy_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= MAXC)
    else $error("block count above table depth");
  a_grow_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr == WR_GROW |-> cnt_q < MAXC)
    else $error("growth into a full table");
  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr == WR_SPLIT |-> cnt_q < MAXC && $past(cmd_i.wr) != WR_K)
    else $error("split into a full table or during a shift");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/ffha_ctrl.sv @@
// sequencer for alloc, free, count-times-size alloc and resize requests
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;
  logic   find_q, find_d;
  logic   second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ctx_q    <= CX_ALLOC;
      find_q   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ctx_q    <= ctx_d;
      find_q   <= find_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctx_d      = ctx_q;
    find_d     = find_q;
    second_d   = second_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.scan_find = find_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_e'(stat_i.cmd))
          OP_ALLOC: begin
            cmd_o.set_req_size = 1'b1;
            ctx_d   = CX_ALLOC;
            state_d = S_A0;
          end
          OP_FREE: begin
            if (stat_i.ptr_zero) begin
              state_d = S_FIN;
            end else begin
              ctx_d = CX_FREE;
              find_d = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          OP_CALLOC: state_d = S_MUL;
          OP_RESIZE: begin
            if (stat_i.ptr_zero) begin
              cmd_o.set_req_size = 1'b1;
              ctx_d   = CX_ALLOC;
              state_d = S_A0;
            end else begin
              ctx_d = CX_RESZ;
              find_d = 1'b1;
              cmd_o.scan_clr = 1'b1;
              state_d = S_SCAN_RD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_MULCHK;
      end
      S_MULCHK: begin
        if (stat_i.prod_hi_nz) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_FAIL;
          state_d = S_FIN;
        end else begin
          cmd_o.set_req_prod = 1'b1;
          ctx_d   = CX_ALLOC;
          state_d = S_A0;
        end
      end
      S_A0: begin
        if (stat_i.req_zero) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_FAIL;
          state_d = S_FIN;
        end else begin
          cmd_o.need_calc = 1'b1;
          cmd_o.scan_clr  = 1'b1;
          find_d  = 1'b0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          if (!find_q) begin
            state_d = S_G1;
          end else begin
            if (ctx_q != CX_RESZ2) begin
              cmd_o.st_set = 1'b1;
              cmd_o.st_val = ST_IGNORED;
            end
            state_d = S_FIN;
          end
        end else begin
          cmd_o.raddr = RA_SCAN;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.scan_match) begin
          cmd_o.take = 1'b1;
          state_d = find_q ? S_FOUND : S_SPL;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d = S_SCAN_RD;
        end
      end
      S_FOUND: begin
        if (ctx_q != CX_RESZ || stat_i.size_zero) begin
          state_d = S_REL;
        end else if (stat_i.fits) begin
          cmd_o.res_ptr = 1'b1;
          state_d = S_FIN;
        end else begin
          // grow by moving: allocate first, old block goes afterwards
          cmd_o.old_load     = 1'b1;
          cmd_o.set_req_size = 1'b1;
          state_d = S_A0;
        end
      end
      S_G1: begin
        cmd_o.grow_prep = 1'b1;
        state_d = S_G2;
      end
      S_G2: begin
        if (stat_i.grow_fail) begin
          cmd_o.st_set = 1'b1;
          cmd_o.st_val = ST_FAIL;
          state_d = S_FIN;
        end else begin
          state_d = S_G3;
        end
      end
      S_G3: begin
        cmd_o.wr = WR_GROW;
        state_d  = S_SPL;
      end
      S_SPL: begin
        if (stat_i.split_ok) begin
          cmd_o.k_load_cnt = 1'b1;
          state_d = S_SH_RD;
        end else begin
          state_d = S_AFIN;
        end
      end
      S_SH_RD: begin
        if (stat_i.sh_more) begin
          cmd_o.raddr = RA_KM1;
          state_d = S_SH_WR;
        end else begin
          state_d = S_SPLIT_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.wr    = WR_K;
        cmd_o.k_dec = 1'b1;
        state_d = S_SH_RD;
      end
      S_SPLIT_WR: begin
        cmd_o.wr = WR_SPLIT;
        state_d  = S_AFIN;
      end
      S_AFIN: begin
        cmd_o.wr      = WR_ALLOC;
        cmd_o.res_ent = 1'b1;
        if (ctx_q == CX_RESZ) begin
          // old block may have moved in the table, look it up again
          cmd_o.copy_old = 1'b1;
          cmd_o.scan_clr = 1'b1;
          ctx_d  = CX_RESZ2;
          find_d = 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_REL: begin
        cmd_o.wr         = WR_FREE;
        cmd_o.j_load_idx = 1'b1;
        second_d = 1'b0;
        state_d  = S_MG0;
      end
      S_MG0: begin
        if (stat_i.mg_skip) begin
          state_d = S_MG_END;
        end else begin
          cmd_o.raddr = RA_J;
          state_d = S_MG1;
        end
      end
      S_MG1: begin
        cmd_o.load_ent = 1'b1;
        cmd_o.raddr    = RA_J1;
        state_d = S_MG2;
      end
      S_MG2: begin
        if (stat_i.mg_ok) begin
          cmd_o.wr        = WR_MERGE;
          cmd_o.k_load_j1 = 1'b1;
          state_d = S_RM_RD;
        end else begin
          state_d = S_MG_END;
        end
      end
      S_RM_RD: begin
        if (stat_i.rm_more) begin
          cmd_o.raddr = RA_K1;
          state_d = S_RM_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d = S_MG_END;
        end
      end
      S_RM_WR: begin
        cmd_o.wr    = WR_K;
        cmd_o.k_inc = 1'b1;
        state_d = S_RM_RD;
      end
      S_MG_END: begin
        if (!second_q && !stat_i.idx_zero) begin
          cmd_o.j_load_idx_m1 = 1'b1;
          second_d = 1'b1;
          state_d  = S_MG0;
        end else begin
          // resize to zero frees and still reports a null result
          if (ctx_q == CX_RESZ) begin
            cmd_o.st_set = 1'b1;
            cmd_o.st_val = ST_FAIL;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator_unit.sv @@
// top level of the first-fit heap allocator
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   command, request_size, item_count, block_address
// out      output     out_valid_o / out_ready_i result_address, status, copy_bytes
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one request at a time; the table scan reads each entry through the single
// memory read port, with a read state and then a check state per entry
// a resize that moves scans the table three times
// reset clears the block count and heap usage; no clearing pass is needed
// a finished result waits in the output register while the next request is taken
`default_nettype none
module first_fit_heap_allocator_unit
  import ffha_pkg::*;
#(
  parameter int MAX_BLOCKS       = 64,
  parameter int HEADER_BYTES     = 20,
  parameter int MIN_SPLIT_BYTES  = 32,
  parameter int GROW_CHUNK_BYTES = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] request_size_i,
  input  wire logic [31:0] item_count_i,
  input  wire logic [31:0] block_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_address_o,
  output logic [1:0]       status_o,
  output logic [31:0]      copy_bytes_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffha_datapath #(
    .MAX_BLOCKS       (MAX_BLOCKS),
    .HEADER_BYTES     (HEADER_BYTES),
    .MIN_SPLIT_BYTES  (MIN_SPLIT_BYTES),
    .GROW_CHUNK_BYTES (GROW_CHUNK_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .command_i        (command_i),
    .request_size_i   (request_size_i),
    .item_count_i     (item_count_i),
    .block_address_i  (block_address_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .result_address_o (result_address_o),
    .status_o         (status_o),
    .copy_bytes_o     (copy_bytes_o)
  );

endmodule
`default_nettype wire
